FILE: rtl/assert_macros.svh
// Assertion macros used by the filter top level.
// No dependencies; include inside a module body after its clock and reset are declared.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock with an active-low reset.
`define BWLP_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the block clock aclk and reset aresetn.
`define BWLP_ASSERT(label, prop, msg) \
    `BWLP_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

FILE: rtl/bwlp_pkg.sv
// Shared types and fixed filter constants for the sixth-order low-pass filter.
// No dependencies; used by bwlp_cell and the top level.
package bwlp_pkg;

    localparam int TAPS        = 6;
    localparam int COEF_W      = 32;  // feedback coefficient, signed Q4.28
    localparam int COEF_FRAC   = 28;
    localparam int INV_W       = 30;  // 1/GAIN, signed Q0.40 scale in 30 bits (positive)
    localparam int GAIN_FRAC   = 40;
    localparam int WGT_W       = 6;   // binomial weight, signed
    localparam int FF_GROWTH   = 6;   // weights sum to 64
    localparam int HIST_INT    = 20;  // integer bits of the output history
    localparam int ACC_GROWTH  = 3;   // six products summed

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [WGT_W-1:0]  wgt_t;
    typedef logic signed [INV_W-1:0]  inv_t;

    // Per-cell control: shift in a new sample, and drop upstream history.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // Feedforward weights for delays one through six.
    localparam wgt_t FF_WGT [TAPS] = '{6'sd6, 6'sd15, 6'sd20, 6'sd15, 6'sd6, 6'sd1};

    // Decimal constants scaled by 1e10, rounded to Q4.28.
    localparam logic [63:0] QC_SCALE = 64'd10000000000;
    localparam logic [63:0] QC_HALF  = 64'd5000000000;
    localparam logic [63:0] FB0_Q = ((64'd35794347983 << COEF_FRAC) + QC_HALF) / QC_SCALE;
    localparam logic [63:0] FB1_Q = ((64'd56586671659 << COEF_FRAC) + QC_HALF) / QC_SCALE;
    localparam logic [63:0] FB2_Q = ((64'd49654152288 << COEF_FRAC) + QC_HALF) / QC_SCALE;
    localparam logic [63:0] FB3_Q = ((64'd25294949058 << COEF_FRAC) + QC_HALF) / QC_SCALE;
    localparam logic [63:0] FB4_Q = ((64'd7052741145  << COEF_FRAC) + QC_HALF) / QC_SCALE;
    localparam logic [63:0] FB5_Q = ((64'd837564796   << COEF_FRAC) + QC_HALF) / QC_SCALE;

    // Feedback coefficients for delays one through six, newest output first.
    localparam coef_t FB_COEF [TAPS] = '{
        coef_t'(FB0_Q[COEF_W-1:0]), -coef_t'(FB1_Q[COEF_W-1:0]),
        coef_t'(FB2_Q[COEF_W-1:0]), -coef_t'(FB3_Q[COEF_W-1:0]),
        coef_t'(FB4_Q[COEF_W-1:0]), -coef_t'(FB5_Q[COEF_W-1:0])
    };

    // round(2^40 / 2936.532839)
    localparam logic [63:0] INV_GAIN_Q =
        ((64'd1 << 41) * 64'd1000000 + 64'd2936532839) / 64'd5873065678;
    localparam inv_t INV_GAIN = inv_t'(INV_GAIN_Q[INV_W-1:0]);

endpackage

FILE: rtl/butterworth_lowpass_6th_order.sv
// Top level of the sixth-order Butterworth low-pass filter.
// Depends on bwlp_pkg, bwlp_cell and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_sample_in, s_restart
//  m_      | out       | m_valid / m_ready  | m_sample_out, m_clipped
//
//  One request is taken per clock while s_ready is high; its result is registered
//  through stage A, stage B and the output register.
//  The feedback loop (round, add, clamp, coefficient multiply, cell add) closes through
//  the cell registers alone and sets the clock; the 1/GAIN multiply has a stage of its own.
//  A stalled output holds; the two stages ahead of it keep filling, so s_ready drops
//  only when all three stages hold a request.
//  Synchronous active-low reset empties the pipeline and zeroes all history cells.
module butterworth_lowpass_6th_order #(
    parameter int SAMPLE_WIDTH      = 16,
    parameter int HISTORY_FRAC_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    input  logic                           s_restart,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    output logic                           m_clipped
);
    import bwlp_pkg::*;
    `include "assert_macros.svh"

    localparam int SW     = SAMPLE_WIDTH;
    localparam int HF     = HISTORY_FRAC_BITS;
    localparam int FF_W   = SW + FF_GROWTH;            // binomial sum
    localparam int HIST_W = HIST_INT + HF;             // output history, Q20.HF
    localparam int GSH    = GAIN_FRAC - HF;            // shift after the 1/GAIN multiply
    localparam int GP_W   = FF_W + INV_W;
    localparam int GR_W   = GP_W + 1;
    localparam int FQ_W   = (GR_W > HIST_W) ? GR_W : HIST_W;
    localparam int ACC_W  = HIST_W + COEF_W + ACC_GROWTH;
    localparam int AR_W   = ACC_W + 1;
    localparam int OR_W   = HIST_W + 1;

    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
    localparam logic signed [SW-1:0]     OUT_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]     OUT_MIN  = {1'b1, {(SW-1){1'b0}}};

    // rounding offsets: one half of the dropped fraction, ties round up
    localparam logic signed [GR_W-1:0] GAIN_HALF =
        {{(GR_W-GSH){1'b0}}, 1'b1, {(GSH-1){1'b0}}};
    localparam logic signed [AR_W-1:0] ACC_HALF =
        {{(AR_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [OR_W-1:0] OUT_HALF =
        {{(OR_W-HF){1'b0}}, 1'b1, {(HF-1){1'b0}}};

    // ---------------------------------------------------------------
    // Pipeline flow: stage A (binomial sum), stage B (scaled by 1/GAIN),
    // feedback loop feeding the output register.
    // ---------------------------------------------------------------
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic m_valid_reg, m_valid_next;
    logic en_out, fire_c, b_free, a_move, a_free, accept;

    assign en_out = !m_valid_reg || m_ready;
    assign fire_c = b_valid_reg && en_out;
    assign b_free = !b_valid_reg || fire_c;
    assign a_move = a_valid_reg && b_free;
    assign a_free = !a_valid_reg || b_free;
    assign accept = s_valid && a_free;

    assign a_valid_next = accept || (a_valid_reg && !b_free);
    assign b_valid_next = a_move || (b_valid_reg && !fire_c);
    assign m_valid_next = fire_c || (m_valid_reg && !m_ready);

    assign s_ready = a_free;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Feedforward chain: cell j holds the weighted input history that
    // is still owed to the sum j+1 requests ahead.
    // ---------------------------------------------------------------
    cell_ctl_t               ff_ctl;
    logic signed [FF_W-1:0]  f_sum [TAPS+1];
    logic signed [FF_W-1:0]  a_ff_next;
    logic signed [FF_W-1:0]  a_ff_reg;
    logic                    a_restart_reg;

    assign ff_ctl.shift = accept;
    assign ff_ctl.clear = s_restart;
    assign f_sum[TAPS]  = '0;

    for (genvar j = 0; j < TAPS; j++) begin : g_ff
        bwlp_cell #(
            .DATA_W (SW),
            .FAC_W  (WGT_W),
            .SUM_W  (FF_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ff_ctl),
            .data    (s_sample_in),
            .factor  (FF_WGT[j]),
            .sum_in  (f_sum[j+1]),
            .sum_out (f_sum[j])
        );
    end

    // current sample has weight one; restart drops all past inputs
    assign a_ff_next = FF_W'(s_sample_in) + (s_restart ? '0 : f_sum[0]);

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_ff_reg      <= a_ff_next;
            a_restart_reg <= s_restart;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: multiply by 1/GAIN, round to HF fraction bits, saturate.
    // ---------------------------------------------------------------
    logic signed [GP_W-1:0]   gain_prod;
    logic signed [GR_W-1:0]   gain_rnd;
    logic signed [FQ_W-1:0]   gain_ext;
    logic signed [HIST_W-1:0] b_ffq_next;
    logic signed [HIST_W-1:0] b_ffq_reg;
    logic                     b_restart_reg;

    assign gain_prod = a_ff_reg * INV_GAIN;

    always_comb begin
        gain_rnd = (GR_W'(gain_prod) + GAIN_HALF) >>> GSH;
        gain_ext = FQ_W'(gain_rnd);
        if (gain_ext > FQ_W'(HIST_MAX)) begin
            b_ffq_next = HIST_MAX;
        end else if (gain_ext < FQ_W'(HIST_MIN)) begin
            b_ffq_next = HIST_MIN;
        end else begin
            b_ffq_next = HIST_W'(gain_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_ffq_reg     <= b_ffq_next;
            b_restart_reg <= a_restart_reg;
        end
    end

    // ---------------------------------------------------------------
    // Feedback loop: cell 0 holds the exact feedback sum for the request
    // in stage B; each new output is scaled into every cell as it fires.
    // ---------------------------------------------------------------
    cell_ctl_t                fb_ctl;
    logic signed [ACC_W-1:0]  s_sum [TAPS+1];
    logic signed [ACC_W-1:0]  fb_acc;
    logic signed [AR_W-1:0]   fb_rnd;
    logic signed [HIST_W-1:0] fbq;
    logic signed [OR_W-1:0]   y_sum;
    logic signed [HIST_W-1:0] y_hist;

    assign fb_ctl.shift = fire_c;
    assign fb_ctl.clear = b_restart_reg;
    assign s_sum[TAPS]  = '0;

    for (genvar j = 0; j < TAPS; j++) begin : g_fb
        bwlp_cell #(
            .DATA_W (HIST_W),
            .FAC_W  (COEF_W),
            .SUM_W  (ACC_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (fb_ctl),
            .data    (y_hist),
            .factor  (FB_COEF[j]),
            .sum_in  (s_sum[j+1]),
            .sum_out (s_sum[j])
        );
    end

    assign fb_acc = b_restart_reg ? '0 : s_sum[0];

    always_comb begin
        // round once to HF fraction bits and saturate to history width
        fb_rnd = (AR_W'(fb_acc) + ACC_HALF) >>> COEF_FRAC;
        if (fb_rnd > AR_W'(HIST_MAX)) begin
            fbq = HIST_MAX;
        end else if (fb_rnd < AR_W'(HIST_MIN)) begin
            fbq = HIST_MIN;
        end else begin
            fbq = HIST_W'(fb_rnd);
        end

        y_sum = OR_W'(b_ffq_reg) + OR_W'(fbq);
        if (y_sum > OR_W'(HIST_MAX)) begin
            y_hist = HIST_MAX;
        end else if (y_sum < OR_W'(HIST_MIN)) begin
            y_hist = HIST_MIN;
        end else begin
            y_hist = HIST_W'(y_sum);
        end
    end

    // ---------------------------------------------------------------
    // Output: round history value to an integer, saturate to sample range.
    // ---------------------------------------------------------------
    logic signed [OR_W-1:0] out_rnd;
    logic signed [SW-1:0]   m_sample_out_next;
    logic                   m_clipped_next;
    logic signed [SW-1:0]   m_sample_out_reg;
    logic                   m_clipped_reg;

    always_comb begin
        out_rnd = (OR_W'(y_hist) + OUT_HALF) >>> HF;
        if (out_rnd > OR_W'(OUT_MAX)) begin
            m_sample_out_next = OUT_MAX;
            m_clipped_next    = 1'b1;
        end else if (out_rnd < OR_W'(OUT_MIN)) begin
            m_sample_out_next = OUT_MIN;
            m_clipped_next    = 1'b1;
        end else begin
            m_sample_out_next = SW'(out_rnd);
            m_clipped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_c) begin
            m_sample_out_reg <= m_sample_out_next;
            m_clipped_reg    <= m_clipped_next;
        end
    end

    assign m_sample_out = m_sample_out_reg;
    assign m_clipped    = m_clipped_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `BWLP_ASSERT(a_ready_with_room,
        !(a_valid_reg && b_valid_reg && m_valid_reg) |-> s_ready,
        "input stalled while a pipeline stage is empty")

    `BWLP_ASSERT(a_fire_fills_output, fire_c |=> m_valid,
        "feedback stage fired but no result was registered")

    `BWLP_ASSERT(a_clip_at_rail,
        m_valid && m_clipped |-> (m_sample_out == OUT_MAX || m_sample_out == OUT_MIN),
        "clipped result is not at a rail")

    `BWLP_ASSERT(a_restart_drops_history,
        s_valid && s_ready && s_restart |=> a_ff_reg == FF_W'($past(s_sample_in)),
        "restart request kept past input history")

endmodule

FILE: rtl/bwlp_cell.sv
// One cell of a transposed tap chain: scale a sample and add the neighbor's partial sum.
// Depends on bwlp_pkg (cell_ctl_t).
module bwlp_cell #(
    parameter int DATA_W = 16,
    parameter int FAC_W  = 6,
    parameter int SUM_W  = 22
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bwlp_pkg::cell_ctl_t        ctl,
    input  logic signed [DATA_W-1:0]   data,
    input  logic signed [FAC_W-1:0]    factor,
    input  logic signed [SUM_W-1:0]    sum_in,
    output logic signed [SUM_W-1:0]    sum_out
);
    import bwlp_pkg::*;

    localparam int PROD_W = DATA_W + FAC_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  upstream;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    assign prod     = data * factor;
    // drop the neighbor's history on restart
    assign upstream = ctl.clear ? '0 : sum_in;
    assign sum_next = SUM_W'(prod) + upstream;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctl.shift) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule
